>>> design/uda_pkg.sv
// shared constants and types for the ultrasonic distance averager
package uda_pkg;

    // ring depth, legal range 1 to 64
    localparam int WINDOW_DEPTH = 8;

    localparam int SLOT_W  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int CNT_W   = $clog2(WINDOW_DEPTH + 1);
    localparam int TICKS_W = 16;
    localparam int DIST_W  = 11;
    localparam int READ_W  = 12;
    // signed sum of up to WINDOW_DEPTH readings of -1 to 1129
    localparam int SUM_W   = READ_W + CNT_W;
    localparam int STEP_W  = $clog2(SUM_W);

    localparam logic [CNT_W-1:0]  DEPTH_CNT = CNT_W'(WINDOW_DEPTH);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW_DEPTH - 1);

    // ticks / 58 as (ticks * ceil(2^22 / 58)) >> 22, exact for 16-bit ticks
    localparam int RECIP_SHIFT = 22;
    localparam int RECIP_W     = 17;
    localparam logic [RECIP_W-1:0] RECIP_58 = RECIP_W'(72316);
    localparam int PROD_W      = TICKS_W + RECIP_W;

    localparam logic [READ_W-1:0] INVALID_CM = {READ_W{1'b1}};

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_LO_LIMIT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_HI_LIMIT = 1'b1;

    localparam logic [DIST_W-1:0] LO_LIMIT_RST = DIST_W'(2);
    localparam logic [DIST_W-1:0] HI_LIMIT_RST = DIST_W'(400);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_MUL   = 7'b0000010,
        S_WRITE = 7'b0000100,
        S_SUM   = 7'b0001000,
        S_SETUP = 7'b0010000,
        S_DIV   = 7'b0100000,
        S_DONE  = 7'b1000000
    } t_state;

endpackage

>>> design/uda_ram.sv
// generic single-port-write, single-port-read ram with registered read
module uda_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 8
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

>>> design/ultrasonic_distance_average.sv
// top level of the ultrasonic distance averager
//
// one echo transaction at a time: each echo pulse width (microsecond ticks)
// is turned into centimetres (ticks / 58, truncated), replaced by -1 when it
// lies outside the configured lower and upper limits, and written into a ring
// of the last WINDOW_DEPTH readings held in a small ram. the filled entries are
// then read back one per cycle and summed, and the sum is divided by the fill
// count with a one-bit-per-cycle restoring divider (truncation toward zero,
// a negative quotient reported as -1). a new echo is not taken until the
// current one has been multiplied, written, summed and divided and its
// result loaded; the single ram read port and the serial divider set how
// long that takes, and the finished result also waits while the output
// register is still stalled. the result sits in an output register, so a
// new echo is taken while the previous result still waits. the ring is
// not cleared after reset: only entries already written are ever summed.
// configuration writes are meant for idle periods only.
module ultrasonic_distance_average
    import uda_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // echo transaction
    input  logic                     i_echo_valid,
    output logic                     o_echo_stall,
    input  logic [TICKS_W-1:0]       i_echo_ticks,
    // result transaction
    output logic                     o_result_valid,
    input  logic                     i_result_stall,
    output logic signed [READ_W-1:0] o_stable_distance,
    // configuration writes
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [DIST_W-1:0]        i_cfg_wdata
);

    // control state
    t_state                r_state, n_state;
    logic [SLOT_W-1:0]     r_slot, n_slot;
    logic [CNT_W-1:0]      r_count, n_count;
    logic [CNT_W-1:0]      r_idx, n_idx;      // next ring entry to read
    logic                  r_rd_v, n_rd_v;    // ram data valid this cycle
    logic [STEP_W-1:0]     r_step, n_step;
    logic                  r_out_v, n_out_v;
    logic [DIST_W-1:0]     r_min, n_min;
    logic [DIST_W-1:0]     r_max, n_max;

    // datapath
    logic [TICKS_W-1:0]    r_ticks, n_ticks;
    logic [PROD_W-1:0]     r_prod, n_prod;
    logic [SUM_W-1:0]      r_sum, n_sum;      // two's complement
    logic [SUM_W-1:0]      r_quo, n_quo;      // dividend in, quotient out
    logic [CNT_W-1:0]      r_rem, n_rem;
    logic                  r_neg, n_neg;
    logic [READ_W-1:0]     r_out, n_out;

    // ram interface
    logic                  ram_we;
    logic [READ_W-1:0]     ram_wdata;
    logic                  ram_re;
    logic [READ_W-1:0]     ram_rdata;

    // helpers
    logic                  echo_acc;
    logic                  out_free;
    logic [DIST_W-1:0]     cm;
    logic [CNT_W:0]        rem_shift;
    logic [CNT_W:0]        cnt_ext;
    logic                  quo_bit;
    logic [READ_W-1:0]     div_result;

    assign o_echo_stall      = (r_state != S_IDLE);
    assign echo_acc          = i_echo_valid && !o_echo_stall;
    assign out_free          = !r_out_v || !i_result_stall;
    assign o_result_valid    = r_out_v;
    assign o_stable_distance = r_out;

    // centimetres from the registered reciprocal product
    assign cm = r_prod[RECIP_SHIFT +: DIST_W];

    // one restoring division step
    assign rem_shift = {r_rem, r_quo[SUM_W-1]};
    assign cnt_ext   = {1'b0, r_count};
    assign quo_bit   = (rem_shift >= cnt_ext);

    // negative sums only ever give 0 or -1 after truncation
    assign div_result = r_neg ? ((|r_quo) ? INVALID_CM : '0) : r_quo[READ_W-1:0];

    always_comb begin
        n_state   = r_state;
        n_slot    = r_slot;
        n_count   = r_count;
        n_idx     = r_idx;
        n_rd_v    = 1'b0;
        n_step    = r_step;
        n_out_v   = r_out_v;
        n_min     = r_min;
        n_max     = r_max;
        n_ticks   = r_ticks;
        n_prod    = r_prod;
        n_sum     = r_sum;
        n_quo     = r_quo;
        n_rem     = r_rem;
        n_neg     = r_neg;
        n_out     = r_out;
        ram_we    = 1'b0;
        ram_wdata = INVALID_CM;
        ram_re    = 1'b0;

        // result register drains independently of the sequencer
        if (r_out_v && !i_result_stall) begin
            n_out_v = 1'b0;
        end

        if (i_cfg_we) begin
            case (i_cfg_index)
                REG_LO_LIMIT: n_min = i_cfg_wdata;
                REG_HI_LIMIT: n_max = i_cfg_wdata;
                default: ;
            endcase
        end

        case (r_state)
            S_IDLE: begin
                if (echo_acc) begin
                    n_ticks = i_echo_ticks;
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                n_prod  = {{RECIP_W{1'b0}}, r_ticks} * {{TICKS_W{1'b0}}, RECIP_58};
                n_state = S_WRITE;
            end
            S_WRITE: begin
                // out-of-range distance becomes the invalid marker
                ram_we    = 1'b1;
                ram_wdata = (cm < r_min || cm > r_max) ? INVALID_CM : {1'b0, cm};
                n_slot    = (r_slot == LAST_SLOT) ? '0 : r_slot + SLOT_W'(1);
                if (r_count != DEPTH_CNT) begin
                    n_count = r_count + CNT_W'(1);
                end
                n_idx   = '0;
                n_sum   = '0;
                n_state = S_SUM;
            end
            S_SUM: begin
                // issue one read per cycle, accumulate the data in the next cycle
                if (r_idx != r_count) begin
                    ram_re = 1'b1;
                    n_idx  = r_idx + CNT_W'(1);
                    n_rd_v = 1'b1;
                end
                if (r_rd_v) begin
                    n_sum = r_sum + {{(SUM_W-READ_W){ram_rdata[READ_W-1]}}, ram_rdata};
                end
                if (r_idx == r_count && !r_rd_v) begin
                    n_state = S_SETUP;
                end
            end
            S_SETUP: begin
                n_neg   = r_sum[SUM_W-1];
                n_quo   = r_sum[SUM_W-1] ? (~r_sum + SUM_W'(1)) : r_sum;
                n_rem   = '0;
                n_step  = '0;
                n_state = S_DIV;
            end
            S_DIV: begin
                n_rem  = quo_bit ? CNT_W'(rem_shift - cnt_ext) : CNT_W'(rem_shift);
                n_quo  = {r_quo[SUM_W-2:0], quo_bit};
                n_step = r_step + STEP_W'(1);
                if (r_step == STEP_W'(SUM_W - 1)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_out   = div_result;
                    n_out_v = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_slot  <= '0;
            r_count <= '0;
            r_idx   <= '0;
            r_rd_v  <= 1'b0;
            r_step  <= '0;
            r_out_v <= 1'b0;
            r_min   <= LO_LIMIT_RST;
            r_max   <= HI_LIMIT_RST;
        end else begin
            r_state <= n_state;
            r_slot  <= n_slot;
            r_count <= n_count;
            r_idx   <= n_idx;
            r_rd_v  <= n_rd_v;
            r_step  <= n_step;
            r_out_v <= n_out_v;
            r_min   <= n_min;
            r_max   <= n_max;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ticks <= n_ticks;
        r_prod  <= n_prod;
        r_sum   <= n_sum;
        r_quo   <= n_quo;
        r_rem   <= n_rem;
        r_neg   <= n_neg;
        r_out   <= n_out;
    end

    // ring of recent readings
    uda_ram #(
        .WIDTH (READ_W),
        .DEPTH (WINDOW_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_slot),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_idx[SLOT_W-1:0]),
        .o_rdata (ram_rdata)
    );

`ifndef NO_ASSERTIONS
    // fill count saturates at the ring depth
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= DEPTH_CNT)
        else $error("fill count above ring depth");

    // an accepted echo starts the conversion
    a_accept_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        echo_acc |=> r_state == S_MUL)
        else $error("accepted echo did not start conversion");

    // ram data only arrives while summing
    a_read_in_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_v |-> r_state == S_SUM)
        else $error("ring read data outside summing phase");

    // divider remainder stays below the divisor
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DIV |-> (r_rem < r_count && r_count != '0))
        else $error("divider remainder out of range");

    // a new result is loaded only from the finishing state
    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && !$past(r_out_v)) |-> $past(r_state) == S_DONE)
        else $error("result appeared without finishing a division");
`endif

endmodule

>>> dv/ultrasonic_distance_average_tb.sv
// self-checking testbench for the ultrasonic distance averager
module ultrasonic_distance_average_tb;
    import uda_pkg::*;

    localparam int CM_TICKS    = 58;
    localparam int INVALID_VAL = -1;
    localparam int IDLE_PCT    = 8;
    localparam int PHASE_ITEMS = 150;
    localparam int NUM_PHASES  = 8;
    // covers the pipeline draining
    localparam int SETTLE      = 40;
    localparam int CYCLE_LIMIT = 600000;
    localparam int NUM_CORNERS = 22;

    // running average predictor plus queue of averages still owed by the block
    class distance_scoreboard;
        int window [WINDOW_DEPTH];
        int next_slot;
        int fill;
        int lo_cm;
        int hi_cm;
        logic signed [READ_W-1:0] pending [$];
        int checked;
        int mismatches;

        function new();
            next_slot = 0;
            fill = 0;
            lo_cm = LO_LIMIT_RST;
            hi_cm = HI_LIMIT_RST;
            checked = 0;
            mismatches = 0;
            foreach (window[i]) window[i] = 0;
        endfunction

        function void set_limits(int lo, int hi);
            lo_cm = lo;
            hi_cm = hi;
        endfunction

        function void flag(string what, int want, int got);
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch %s: expected %0d actual %0d", what, want, got);
        endfunction

        // one accepted echo transaction yields exactly one average
        function void note_echo(logic [TICKS_W-1:0] ticks);
            int cm;
            int sum;
            int avg;
            cm = int'(ticks) / CM_TICKS;
            window[next_slot] = (cm < lo_cm || cm > hi_cm) ? INVALID_VAL : cm;
            next_slot = (next_slot == WINDOW_DEPTH - 1) ? 0 : next_slot + 1;
            if (fill < WINDOW_DEPTH)
                fill++;
            sum = 0;
            for (int i = 0; i < fill; i++)
                sum += window[i];
            // int division truncates toward zero
            avg = sum / fill;
            if (avg < 0)
                avg = INVALID_VAL;
            pending.push_back(READ_W'(avg));
        endfunction

        function void check_result(logic signed [READ_W-1:0] got);
            logic signed [READ_W-1:0] want;
            if (pending.size() == 0) begin
                flag("unexpected result", 0, got);
            end else begin
                want = pending.pop_front();
                checked++;
                if (want !== got)
                    flag("stable_distance", want, got);
            end
        endfunction

        function void report_leftover();
            while (pending.size() != 0)
                flag("missing result", pending.pop_front(), 0);
        endfunction
    endclass

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_echo_valid = 1'b0;
    logic                     o_echo_stall;
    logic [TICKS_W-1:0]       i_echo_ticks = '0;
    logic                     o_result_valid;
    logic                     i_result_stall = 1'b0;
    logic signed [READ_W-1:0] o_stable_distance;
    logic                     i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]     i_cfg_index = REG_LO_LIMIT;
    logic [DIST_W-1:0]        i_cfg_wdata = '0;

    distance_scoreboard sb;
    int  cycle_count = 0;
    int  items_sent = 0;
    int  settings_used = 1;
    // when set, neither side inserts gaps or stalls
    bit  calm = 1'b0;

    // boundaries of the conversion and the default window, plus all-ones/zeros patterns
    logic [TICKS_W-1:0] corner_ticks [NUM_CORNERS] = '{
        16'd0, 16'd116, 16'd57, 16'd115, 16'd23200, 16'd23257, 16'd23258, 16'd65535,
        16'd58, 16'd173, 16'd174, 16'd12345, 16'hAAAA, 16'h5555, 16'd65535,
        16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd116, 16'd23200
    };

    ultrasonic_distance_average dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_echo_valid      (i_echo_valid),
        .o_echo_stall      (o_echo_stall),
        .i_echo_ticks      (i_echo_ticks),
        .o_result_valid    (o_result_valid),
        .i_result_stall    (i_result_stall),
        .o_stable_distance (o_stable_distance),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_wdata       (i_cfg_wdata)
    );

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    // random backpressure on the result side
    always @(posedge i_clk) begin
        i_result_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
    end

    // values read here are the ones present at the edge
    always @(posedge i_clk) begin
        if (i_rst_n && o_result_valid && !i_result_stall)
            sb.check_result(o_stable_distance);
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles", cycle_count);
        $display("*** FAILED ***");
        $finish;
    end

    // valid is left high on return so back-to-back transactions never toggle it
    task automatic send_echo(input logic [TICKS_W-1:0] ticks);
        int gap;
        if (!calm && $urandom_range(99) < IDLE_PCT) begin
            gap = $urandom_range(1, 12);
            i_echo_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_echo_valid <= 1'b1;
        i_echo_ticks <= ticks;
        do @(posedge i_clk); while (o_echo_stall);
        sb.note_echo(ticks);
        items_sent++;
    endtask

    // stop sending and let every outstanding average come back
    task automatic drain();
        i_echo_valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // both limits written one after the other, low limit first, block idle
    task automatic write_limits(input int lo, input int hi);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= REG_LO_LIMIT;
        i_cfg_wdata <= DIST_W'(lo);
        @(posedge i_clk);
        i_cfg_index <= REG_HI_LIMIT;
        i_cfg_wdata <= DIST_W'(hi);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_limits(lo, hi);
        settings_used++;
    endtask

    // mostly pulses near the current limits, some spread over the range, some fully random
    function automatic logic [TICKS_W-1:0] pick_ticks(input int lo, input int hi);
        int bound;
        int cm;
        int t;
        case ($urandom_range(9))
            0, 1, 2, 3, 4: begin
                bound = $urandom_range(1) ? lo : hi;
                cm = bound + int'($urandom_range(4)) - 2;
                if (cm < 0)
                    cm = 0;
                t = cm * CM_TICKS + int'($urandom_range(CM_TICKS - 1));
            end
            5, 6, 7: t = $urandom_range(0, 1131 * CM_TICKS);
            default: t = $urandom_range(65535);
        endcase
        if (t > 65535)
            t = 65535;
        return TICKS_W'(t);
    endfunction

    initial begin
        int lo;
        int hi;
        sb = new();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed pass under the reset limits: fresh ring fill, wrap, negative averages
        foreach (corner_ticks[i])
            send_echo(corner_ticks[i]);
        drain();

        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0: begin lo = 0;    hi = 1129; end
                1: begin lo = 1129; hi = 0;    end  // minimum above maximum
                2: begin lo = 150;  hi = 600;  end
                3: begin lo = 2;    hi = 400;  end
                4: begin lo = 0;    hi = 0;    end
                5: begin lo = 1129; hi = 1129; end
                6: begin lo = 1023; hi = 1023; end
                default: begin
                    lo = $urandom_range(1129);
                    hi = $urandom_range(1129);
                end
            endcase
            write_limits(lo, hi);
            // one phase runs with no gaps and no stalls at all
            calm = (p == 3);
            repeat (PHASE_ITEMS)
                send_echo(pick_ticks(lo, hi));
            drain();
            calm = 1'b0;
        end

        sb.report_leftover();
        $display("run covered %0d echo transactions under %0d limit settings",
                 items_sent, settings_used);
        $display("%0d averages compared, %0d mismatches", sb.checked, sb.mismatches);
        if (sb.mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

>>> ultrasonic_distance_average.f
design/uda_pkg.sv
design/uda_ram.sv
design/ultrasonic_distance_average.sv
dv/ultrasonic_distance_average_tb.sv
